// File: rtl/kpl_pkg.sv
// Shared types and constants of the keypad password lock.
// Used by kpl_code_ram, kpl_match_unit and keypad_password_lock; no dependencies.
`timescale 1ns / 1ps

package kpl_pkg;

    // Item kinds carried in the input tuser field.
    localparam logic [2:0] KIND_KEY      = 3'd0;
    localparam logic [2:0] KIND_TERM     = 3'd1;
    localparam logic [2:0] KIND_BTN_CHG  = 3'd2;
    localparam logic [2:0] KIND_BTN_TERM = 3'd3;
    localparam logic [2:0] KIND_BTN_SET  = 3'd4;

    // Special bytes.
    localparam logic [7:0] SYM_STAR = 8'd42;
    localparam logic [7:0] SYM_HASH = 8'd35;
    localparam logic [7:0] SYM_CR   = 8'd13;

    // Result event codes.
    localparam logic [3:0] EV_IGNORED = 4'd0;
    localparam logic [3:0] EV_STORED  = 4'd1;
    localparam logic [3:0] EV_DROPPED = 4'd2;
    localparam logic [3:0] EV_CLEARED = 4'd3;
    localparam logic [3:0] EV_GRANTED = 4'd4;
    localparam logic [3:0] EV_DENIED  = 4'd5;
    localparam logic [3:0] EV_CHANGED = 4'd6;
    localparam logic [3:0] EV_EMPTY   = 4'd7;
    localparam logic [3:0] EV_MODE    = 4'd8;

    // Operating modes.
    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_CHANGE   = 2'd1,
        MODE_TERMINAL = 2'd2,
        MODE_SETTING  = 2'd3
    } t_mode;

    // Password that is in force after reset.
    localparam int DFLT_LEN = 4;
    localparam logic [7:0] DFLT_SECRET [0:DFLT_LEN-1] = '{8'h39, 8'h38, 8'h37, 8'h35};

    // Status returned by the serial compare unit.
    typedef struct packed {
        logic done;
        logic match;
    } t_match_sts;

endpackage

// File: rtl/keypad_password_lock.sv
// Keypad password lock: each accepted item's result is loaded into the result register
// at the accepting edge, except '*' in normal mode with an entry as long as the password,
// which waits for the byte-serial compare through the two-port code RAM.
// Input is taken whenever the lock is not comparing and the result register is free
// or draining. Synchronous active-low reset restores normal mode, an empty entry and
// the password "9875" at once; the code RAM itself is never cleared.
`timescale 1ns / 1ps

module keypad_password_lock #(
    parameter int MAX_CODE_LEN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] symbol
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [3:0] event_res, [5:4] current_mode, [5+CNT_W:6] entry_count, rest zero
    output logic [((6 + $clog2(MAX_CODE_LEN + 1) + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);

    localparam int AW     = $clog2(MAX_CODE_LEN);
    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int OUT_DW = ((6 + CNT_W + 7) / 8) * 8;
    localparam int PAD_W  = OUT_DW - 6 - CNT_W;

    typedef enum logic {
        S_IDLE,
        S_CHECK
    } t_state;

    t_state             r_state, n_state;
    kpl_pkg::t_mode     r_mode, n_mode;
    logic [CNT_W-1:0]   r_elen, n_elen;
    logic [CNT_W-1:0]   r_slen, n_slen;
    logic               r_sbank, n_sbank;
    logic               r_dflt, n_dflt;
    logic               r_m_valid, n_m_valid;
    logic [3:0]         r_ev, n_ev;
    kpl_pkg::t_mode     r_out_mode, n_out_mode;
    logic [CNT_W-1:0]   r_out_cnt, n_out_cnt;

    logic               in_acc;
    logic               take_out;
    logic [3:0]         ev;
    logic               wr_en;
    logic               match_start;
    logic               do_store;
    logic               do_change;
    logic [2:0]         kind;
    logic [7:0]         sym;
    logic [AW-1:0]      rd_idx;
    logic [7:0]         entry_byte;
    logic [7:0]         secret_byte;
    kpl_pkg::t_match_sts match_sts;

    assign kind            = i_s_axis_tuser;
    assign sym             = i_s_axis_tdata;
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // Entry bank is the one the password is not in.
    kpl_code_ram #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_code_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_bank   (~r_sbank),
        .i_wr_idx    (r_elen[AW-1:0]),
        .i_wr_data   (sym),
        .i_rd_a_bank (~r_sbank),
        .i_rd_b_bank (r_sbank),
        .i_rd_idx    (rd_idx),
        .i_dflt      (r_dflt),
        .o_rd_a_data (entry_byte),
        .o_rd_b_data (secret_byte)
    );

    kpl_match_unit #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_match (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (match_start),
        .i_len         (r_elen),
        .o_rd_idx      (rd_idx),
        .i_entry_byte  (entry_byte),
        .i_secret_byte (secret_byte),
        .o_sts         (match_sts)
    );

    // Decode one accepted item, or the end of a compare, into its effect on the lock state.
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_elen      = r_elen;
        n_slen      = r_slen;
        n_sbank     = r_sbank;
        n_dflt      = r_dflt;
        n_m_valid   = r_m_valid && !i_m_axis_tready;
        n_ev        = r_ev;
        n_out_mode  = r_out_mode;
        n_out_cnt   = r_out_cnt;
        take_out    = 1'b0;
        ev          = kpl_pkg::EV_IGNORED;
        wr_en       = 1'b0;
        match_start = 1'b0;
        do_store    = 1'b0;
        do_change   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    take_out = 1'b1;
                    case (kind) inside
                        kpl_pkg::KIND_KEY: begin
                            if (r_mode != kpl_pkg::MODE_TERMINAL) begin
                                if (sym == kpl_pkg::SYM_HASH) begin
                                    n_elen = '0;
                                    ev     = kpl_pkg::EV_CLEARED;
                                end else if (sym == kpl_pkg::SYM_STAR) begin
                                    if (r_mode == kpl_pkg::MODE_NORMAL) begin
                                        n_elen = '0;
                                        if (r_elen != r_slen) begin
                                            ev = kpl_pkg::EV_DENIED;
                                        end else begin
                                            match_start = 1'b1;
                                            take_out    = 1'b0;
                                            n_state     = S_CHECK;
                                        end
                                    end else if (r_mode == kpl_pkg::MODE_CHANGE) begin
                                        do_change = 1'b1;
                                    end
                                end else begin
                                    do_store = 1'b1;
                                end
                            end
                        end
                        kpl_pkg::KIND_TERM: begin
                            if (r_mode == kpl_pkg::MODE_TERMINAL) begin
                                if (sym == kpl_pkg::SYM_CR) begin
                                    do_change = 1'b1;
                                end else begin
                                    do_store = 1'b1;
                                end
                            end
                        end
                        kpl_pkg::KIND_BTN_CHG, kpl_pkg::KIND_BTN_TERM,
                        kpl_pkg::KIND_BTN_SET: begin
                            if (r_mode != kpl_pkg::MODE_TERMINAL) begin
                                n_elen = '0;
                                ev     = kpl_pkg::EV_MODE;
                                if (kind == kpl_pkg::KIND_BTN_CHG) begin
                                    n_mode = kpl_pkg::MODE_CHANGE;
                                end else if (kind == kpl_pkg::KIND_BTN_TERM) begin
                                    n_mode = kpl_pkg::MODE_TERMINAL;
                                end else begin
                                    n_mode = kpl_pkg::MODE_SETTING;
                                end
                            end
                        end
                        default: begin
                            ev = kpl_pkg::EV_IGNORED;
                        end
                    endcase

                    // Append a byte unless the entry is full.
                    if (do_store) begin
                        if (r_elen >= CNT_W'(MAX_CODE_LEN)) begin
                            ev = kpl_pkg::EV_DROPPED;
                        end else begin
                            wr_en  = 1'b1;
                            n_elen = r_elen + 1'b1;
                            ev     = kpl_pkg::EV_STORED;
                        end
                    end

                    // A new password takes over the entry bank by swapping banks.
                    if (do_change) begin
                        if (r_elen == '0) begin
                            ev = kpl_pkg::EV_EMPTY;
                        end else begin
                            n_sbank = ~r_sbank;
                            n_dflt  = 1'b0;
                            n_slen  = r_elen;
                            n_elen  = '0;
                            n_mode  = kpl_pkg::MODE_NORMAL;
                            ev      = kpl_pkg::EV_CHANGED;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (match_sts.done) begin
                    n_m_valid  = 1'b1;
                    n_ev       = match_sts.match ? kpl_pkg::EV_GRANTED : kpl_pkg::EV_DENIED;
                    n_out_mode = r_mode;
                    n_out_cnt  = r_elen;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the result register for items that finish at once.
        if (take_out) begin
            n_m_valid  = 1'b1;
            n_ev       = ev;
            n_out_mode = n_mode;
            n_out_cnt  = n_elen;
        end
    end

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= kpl_pkg::MODE_NORMAL;
            r_elen     <= '0;
            r_slen     <= CNT_W'(kpl_pkg::DFLT_LEN);
            r_sbank    <= 1'b0;
            r_dflt     <= 1'b1;
            r_m_valid  <= 1'b0;
            r_ev       <= kpl_pkg::EV_IGNORED;
            r_out_mode <= kpl_pkg::MODE_NORMAL;
            r_out_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_elen     <= n_elen;
            r_slen     <= n_slen;
            r_sbank    <= n_sbank;
            r_dflt     <= n_dflt;
            r_m_valid  <= n_m_valid;
            r_ev       <= n_ev;
            r_out_mode <= n_out_mode;
            r_out_cnt  <= n_out_cnt;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {PAD_W'(0), r_out_cnt, r_out_mode, r_ev};

endmodule

// File: rtl/kpl_code_ram.sv
// Code memory holding two byte banks: one holds the password, the other the entry.
// One write port and two registered read ports; uses kpl_pkg for the reset password.
`timescale 1ns / 1ps

module kpl_code_ram #(
    parameter int MAX_CODE_LEN = 16,
    localparam int AW = $clog2(MAX_CODE_LEN)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic          i_wr_bank,
    input  logic [AW-1:0] i_wr_idx,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_a_bank,
    input  logic          i_rd_b_bank,
    input  logic [AW-1:0] i_rd_idx,
    input  logic          i_dflt,      // Port B reads the reset password.
    output logic [7:0]    o_rd_a_data,
    output logic [7:0]    o_rd_b_data
);

    localparam int DEPTH = 2 ** (AW + 1);

    logic [7:0]    r_mem [0:DEPTH-1];
    logic [7:0]    r_rd_a;
    logic [7:0]    r_rd_b;
    logic [AW-1:0] r_rd_idx;
    logic [7:0]    dflt_byte;

    // Write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[{i_wr_bank, i_wr_idx}] <= i_wr_data;
        end
        r_rd_a   <= r_mem[{i_rd_a_bank, i_rd_idx}];
        r_rd_b   <= r_mem[{i_rd_b_bank, i_rd_idx}];
        r_rd_idx <= i_rd_idx;
    end

    // The reset password is a constant table until the first change.
    always_comb begin
        dflt_byte = 8'd0;
        if ({1'b0, r_rd_idx} < (AW + 1)'(kpl_pkg::DFLT_LEN)) begin
            dflt_byte = kpl_pkg::DFLT_SECRET[r_rd_idx[1:0]];
        end
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = i_dflt ? dflt_byte : r_rd_b;

endmodule

// File: rtl/kpl_match_unit.sv
// Byte-serial comparator of the entry against the password.
// Steps an index through the code RAM and compares one byte pair per cycle; uses kpl_pkg.
`timescale 1ns / 1ps

module kpl_match_unit #(
    parameter int MAX_CODE_LEN = 16,
    localparam int AW = $clog2(MAX_CODE_LEN),
    localparam int CNT_W = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CNT_W-1:0]    i_len,      // Nonzero byte count to compare.
    output logic [AW-1:0]       o_rd_idx,
    input  logic [7:0]          i_entry_byte,
    input  logic [7:0]          i_secret_byte,
    output kpl_pkg::t_match_sts o_sts
);

    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_len;
    logic             r_issue;
    logic             r_chk;
    logic             r_chk_last;
    logic             r_same;
    logic             idx_last;
    logic             byte_eq;

    assign idx_last = (r_idx == r_len - 1'b1);
    assign byte_eq  = (i_entry_byte == i_secret_byte);
    assign o_rd_idx = r_idx[AW-1:0];

    // Issue one read per cycle; the data is checked in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue    <= 1'b0;
            r_chk      <= 1'b0;
            r_chk_last <= 1'b0;
            r_same     <= 1'b1;
            r_idx      <= '0;
            r_len      <= '0;
        end else if (i_start) begin
            r_issue    <= 1'b1;
            r_chk      <= 1'b0;
            r_chk_last <= 1'b0;
            r_same     <= 1'b1;
            r_idx      <= '0;
            r_len      <= i_len;
        end else begin
            r_chk      <= r_issue;
            r_chk_last <= r_issue && idx_last;
            if (r_issue) begin
                r_idx <= r_idx + 1'b1;
                if (idx_last) begin
                    r_issue <= 1'b0;
                end
            end
            if (r_chk && !byte_eq) begin
                r_same <= 1'b0;
            end
        end
    end

    assign o_sts.done  = r_chk && r_chk_last;
    assign o_sts.match = r_same && byte_eq;

endmodule
